// ----- src/swmf_pkg.sv -----
// Shared constants and types of the sliding-window maximum filter.
package swmf_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int WIN_W        = 7;
    localparam int POS_W        = $clog2(2 * WINDOW_MAX);
    localparam int FILL_W       = $clog2(WINDOW_MAX + 1);

    typedef struct packed {
        logic                           valid;
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic [POS_W-1:0]               pos;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] max_value;
        logic                           short_window;
        logic                           end_of_run;
    } result_t;

endpackage

// ----- src/sliding_window_max_filter.sv -----
// Sliding-window maximum filter: a monotonic deque held in a row of cells.
//
// Input channel: sample_valid, sample_stall, with sample, first and last.
// A word is taken at a clock edge where sample_valid is high and
// sample_stall is low. first restarts the sequence; last ends it.
// Result channel: result_valid, result_stall, with max_value, short_window
// and end_of_run. A word yields one result once the window has filled, or
// on last (then short_window flags a partial maximum); otherwise none.
// A result is registered in the output register, or in its skid stage
// while the receiver stalls. Throughput is one word per cycle unless
// sample_stall is high; after window_size is lowered, the input stalls
// while expired head entries are drained, one per cycle. window_size is
// written through window_size_wr and takes effect with the next word.
// Reset empties the deque, clears the counters and sets window_size to 3.
// A stalled receiver fills the output register and then its skid stage;
// the input is stalled once both hold a word, and while the head drains.
module sliding_window_max_filter
    import swmf_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           window_size_wr,
    input  logic [WIN_W-1:0]               window_size,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           first,
    input  logic                           last,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic signed [SAMPLE_WIDTH-1:0] max_value,
    output logic                           short_window,
    output logic                           end_of_run
);

    logic [WIN_W-1:0]  window_size_reg;
    logic [WIN_W-1:0]  window_size_next;
    logic [POS_W-1:0]  pos_counter_reg;
    logic [POS_W-1:0]  pos_counter_next;
    logic [FILL_W-1:0] fill_count_reg;
    logic [FILL_W-1:0] fill_count_next;

    entry_t            entries [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] keeps;
    logic [WINDOW_MAX-1:0] valid_vec;
    cell_ctrl_t        ctrl;

    logic [WIN_W-1:0]  win_eff;
    logic [POS_W-1:0]  pos_cur;
    logic [POS_W-1:0]  age0;
    logic [POS_W-1:0]  age1;
    logic              exp0;
    logic              exp1;
    logic              drain;
    logic              accept;
    logic              drop_head;
    logic              emit;
    logic              buf_full;
    result_t           push_data;
    result_t           result_data;

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (window_size_reg > WIN_W'(WINDOW_MAX))
        begin
            win_eff = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            win_eff = window_size_reg;
        end
    end

    // Ages wrap modulo twice the largest window, so a plain subtract works.
    assign pos_cur = first ? '0 : pos_counter_reg;
    assign age0    = pos_counter_reg - entries[0].pos;
    assign age1    = pos_counter_reg - entries[1].pos;
    assign exp0    = entries[0].valid && (POS_W'(age0) >= POS_W'(win_eff));
    assign exp1    = entries[1].valid && (POS_W'(age1) >= POS_W'(win_eff));

    // More than one expired entry at the head: drop one per cycle first.
    assign drain        = sample_valid && !first && exp1;
    assign sample_stall = drain || buf_full;
    assign accept       = sample_valid && !sample_stall;

    // A survivor in the last cell means the row is full and must make room.
    assign drop_head = !first && (exp0 || keeps[WINDOW_MAX-1]);

    assign ctrl.accept = accept;
    assign ctrl.shift  = accept ? drop_head : drain;
    assign ctrl.clear  = first;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            logic   left_keep;
            entry_t right_entry;
            logic   right_keep;

            if (gi == 0)
            begin : g_head
                assign left_keep = 1'b1;
            end
            else
            begin : g_body
                assign left_keep = keeps[gi-1];
            end

            if (gi == WINDOW_MAX - 1)
            begin : g_tail
                assign right_entry = '0;
                assign right_keep  = 1'b0;
            end
            else
            begin : g_inner
                assign right_entry = entries[gi+1];
                assign right_keep  = keeps[gi+1];
            end

            swmf_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .sample      (sample),
                .pos         (pos_cur),
                .at_head     (gi == 0),
                .left_keep   (left_keep),
                .right_entry (right_entry),
                .right_keep  (right_keep),
                .entry       (entries[gi]),
                .keep        (keeps[gi])
            );

            assign valid_vec[gi] = entries[gi].valid;
        end
    endgenerate

    always_comb
    begin
        if (first)
        begin
            fill_count_next = FILL_W'(1);
        end
        else if (fill_count_reg >= FILL_W'(WINDOW_MAX))
        begin
            fill_count_next = fill_count_reg;
        end
        else
        begin
            fill_count_next = fill_count_reg + FILL_W'(1);
        end
    end

    assign pos_counter_next = pos_cur + POS_W'(1);
    assign window_size_next = window_size_wr ? window_size : window_size_reg;

    // The head after this word lands: first survivor, or the word itself.
    always_comb
    begin
        push_data.max_value = sample;
        if (!first)
        begin
            if (drop_head)
            begin
                if (keeps[1])
                begin
                    push_data.max_value = entries[1].value;
                end
            end
            else if (keeps[0])
            begin
                push_data.max_value = entries[0].value;
            end
        end
        push_data.short_window = !(fill_count_next >= FILL_W'(win_eff));
        push_data.end_of_run   = last;
    end

    assign emit = (fill_count_next >= FILL_W'(win_eff)) || last;

    swmf_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept && emit),
        .push_data    (push_data),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_data  (result_data),
        .full         (buf_full)
    );

    assign max_value    = result_data.max_value;
    assign short_window = result_data.short_window;
    assign end_of_run   = result_data.end_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_W'(3);
            pos_counter_reg <= '0;
            fill_count_reg  <= '0;
        end
        else
        begin
            window_size_reg <= window_size_next;
            if (accept)
            begin
                pos_counter_reg <= pos_counter_next;
                fill_count_reg  <= fill_count_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_valid_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("deque cells are not filled from the head without gaps");

    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && first) |=> (valid_vec == WINDOW_MAX'(1)))
        else $error("a first word did not leave exactly one entry");

    a_drain_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
        drain |=> ($countones(valid_vec) == $countones($past(valid_vec)) - 1))
        else $error("a drain cycle did not drop exactly one head entry");
`endif

endmodule

// ----- src/swmf_cell.sv -----
// One deque cell: holds one stored entry and trades it with its neighbors.
module swmf_cell
    import swmf_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cell_ctrl_t                     ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic [POS_W-1:0]               pos,
    input  logic                           at_head,
    input  logic                           left_keep,
    input  entry_t                         right_entry,
    input  logic                           right_keep,
    output entry_t                         entry,
    output logic                           keep
);

    logic                           valid_reg;
    logic                           valid_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic signed [SAMPLE_WIDTH-1:0] value_next;
    logic [POS_W-1:0]               pos_reg;
    logic [POS_W-1:0]               pos_next;

    // An entry survives a new word only if it is strictly greater.
    assign keep = valid_reg && (value_reg > sample);

    assign entry.valid = valid_reg;
    assign entry.value = value_reg;
    assign entry.pos   = pos_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        if (ctrl.accept && ctrl.clear)
        begin
            valid_next = at_head;
            value_next = sample;
            pos_next   = pos;
        end
        else if (ctrl.accept && ctrl.shift)
        begin
            // The head is dropped, so every survivor moves one cell toward it.
            if (right_keep)
            begin
                valid_next = 1'b1;
                value_next = right_entry.value;
                pos_next   = right_entry.pos;
            end
            else if (keep || at_head)
            begin
                valid_next = 1'b1;
                value_next = sample;
                pos_next   = pos;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
        else if (ctrl.accept)
        begin
            if (!keep)
            begin
                valid_next = left_keep;
                value_next = sample;
                pos_next   = pos;
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = right_entry.valid;
            value_next = right_entry.value;
            pos_next   = right_entry.pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

endmodule

// ----- src/swmf_out_buf.sv -----
// Output register with a skid stage for the result channel.
module swmf_out_buf
    import swmf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    result_stall,
    output logic    result_valid,
    output result_t result_data,
    output logic    full
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    main_free;

    assign main_free    = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;
    assign full         = skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef NO_ASSERTIONS
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a word while the output register is empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && skid_valid_reg))
        else $error("result pushed while the skid stage is full");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result_data)))
        else $error("a stalled result word changed or vanished");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the sliding-window maximum filter.
module testbench
    import swmf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int IDLE_SETTLE = 80;
    localparam int RANDOM_WORDS = 1350;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           first;
        logic                           last;
    } sample_word_t;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic [POS_W-1:0]               pos;
    } window_slot_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           window_size_wr = 1'b0;
    logic [WIN_W-1:0]               window_size = WIN_W'(3);
    logic                           sample_valid = 1'b0;
    logic                           sample_stall;
    logic signed [SAMPLE_WIDTH-1:0] sample = '0;
    logic                           first = 1'b0;
    logic                           last = 1'b0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] max_value;
    logic                           short_window;
    logic                           end_of_run;

    // Predictor state: the window copy, position and fill counters.
    window_slot_t     window_q[$];
    logic [POS_W-1:0] next_pos = '0;
    int               fill_cnt = 0;
    logic [WIN_W-1:0] window_setting = WIN_W'(3);

    sample_word_t     pending_words[$];
    result_t          expected_max[$];
    sample_word_t     next_word;
    result_t          want;
    int               error_count = 0;
    int               pushed_words = 0;
    int               accepted_words = 0;
    int               quiet_cycles = 0;
    logic             steady;
    logic [WIN_W-1:0] extreme_windows [6] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2};

    sliding_window_max_filter u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_size_wr (window_size_wr),
        .window_size    (window_size),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .first          (first),
        .last           (last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .max_value      (max_value),
        .short_window   (short_window),
        .end_of_run     (end_of_run)
    );

    always #10 clk = ~clk;

    // Neither side idles while this stretch of words goes through.
    assign steady = (accepted_words >= 500) && (accepted_words < 800);

    function automatic int effective_span(input logic [WIN_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(w);
    endfunction

    function automatic void advance_window(input logic signed [SAMPLE_WIDTH-1:0] s,
                                           input logic f, input logic l);
        int           span;
        result_t      r;
        window_slot_t slot;
        span = effective_span(window_setting);
        if (f)
        begin
            window_q.delete();
            next_pos = '0;
            fill_cnt = 0;
        end
        // Expire the oldest entries, then drop smaller or equal ones from the tail.
        while (window_q.size() > 0 && POS_W'(next_pos - window_q[0].pos) >= span)
            window_q.delete(0);
        while (window_q.size() > 0 && window_q[window_q.size()-1].value <= s)
            window_q.delete(window_q.size() - 1);
        if (window_q.size() >= WINDOW_MAX)
            window_q.delete(0);
        slot.value = s;
        slot.pos = next_pos;
        window_q.insert(window_q.size(), slot);
        next_pos = next_pos + 1'b1;
        if (fill_cnt < WINDOW_MAX)
            fill_cnt++;
        r.max_value = window_q[0].value;
        r.end_of_run = l;
        if (fill_cnt >= span)
        begin
            r.short_window = 1'b0;
            expected_max.insert(expected_max.size(), r);
        end
        else if (l)
        begin
            r.short_window = 1'b1;
            expected_max.insert(expected_max.size(), r);
        end
    endfunction

    task automatic report_error(input string what);
        error_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    // Driver: presents queued words and feeds every accepted one to the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                advance_window(sample, first, last);
                accepted_words <= accepted_words + 1;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 17))
                begin
                    next_word = pending_words[0];
                    pending_words.delete(0);
                    sample <= next_word.sample;
                    first <= next_word.first;
                    last <= next_word.last;
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_max.size() == 0)
                begin
                    report_error($sformatf("unexpected result: max %0d short %0b end %0b",
                                           max_value, short_window, end_of_run));
                end
                else
                begin
                    want = expected_max[0];
                    expected_max.delete(0);
                    if (max_value !== want.max_value || short_window !== want.short_window ||
                        end_of_run !== want.end_of_run)
                        report_error($sformatf({"result mismatch: got max %0d short %0b end %0b,",
                                                " expected max %0d short %0b end %0b"},
                                               max_value, short_window, end_of_run,
                                               want.max_value, want.short_window,
                                               want.end_of_run));
                end
            end
            result_stall <= !steady && ($urandom_range(99) < 17);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_word(input int value, input logic f, input logic l);
        sample_word_t w;
        w.sample = SAMPLE_WIDTH'(value);
        w.first = f;
        w.last = l;
        pending_words.insert(pending_words.size(), w);
        pushed_words++;
    endtask

    task automatic set_window(input logic [WIN_W-1:0] w);
        @(posedge clk);
        window_size_wr <= 1'b1;
        window_size <= w;
        @(posedge clk);
        window_size_wr <= 1'b0;
        window_setting = w;
    endtask

    // Checked on the falling edge so that all updates of the rising edge have settled.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || sample_valid || expected_max.size() != 0);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic add_noise(input int count);
        for (int i = 0; i < count; i++)
            push_word(int'($urandom), $urandom_range(9) == 0, $urandom_range(5) == 0);
    endtask

    task automatic add_sequence(input int len, input logic open_start, input logic close);
        int shape;
        int base;
        int step;
        int v;
        shape = $urandom_range(3);
        base = int'($urandom);
        step = $urandom_range(1, 40);
        for (int i = 0; i < len; i++)
        begin
            case (shape)
                0: v = int'($urandom);
                1: v = int'($urandom_range(6)) - 3;
                2: v = base - i * step;
                default: v = base + i * step;
            endcase
            push_word(v, (i == 0) && !open_start, (i == len - 1) && close);
        end
    endtask

    initial
    begin
        logic [WIN_W-1:0] w;
        int               span;
        int               kind;
        int               phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Window of three after reset: sample extremes, a one-word sequence, a tie.
        push_word(32767, 1'b1, 1'b0);
        push_word(-32768, 1'b0, 1'b0);
        push_word(-32768, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(-1, 1'b0, 1'b1);
        push_word(-32768, 1'b1, 1'b1);
        push_word(5, 1'b1, 1'b0);
        push_word(5, 1'b0, 1'b1);
        wait_idle();
        set_window(7'd0);
        push_word(100, 1'b1, 1'b0);
        push_word(200, 1'b0, 1'b0);
        push_word(-300, 1'b0, 1'b1);
        wait_idle();
        set_window(7'd127);
        push_word(-5, 1'b1, 1'b0);
        push_word(7, 1'b0, 1'b0);
        push_word(7, 1'b0, 1'b0);
        push_word(-32768, 1'b0, 1'b1);
        wait_idle();
        set_window(7'd5);
        for (int i = 0; i < 6; i++)
            push_word(600 - 100 * i, i == 0, 1'b0);
        wait_idle();
        // Shrinking the window mid-sequence must retire the older entries.
        set_window(7'd2);
        push_word(-1000, 1'b0, 1'b0);
        push_word(-2000, 1'b0, 1'b0);
        push_word(-3000, 1'b0, 1'b1);
        wait_idle();

        phase = 0;
        while (pushed_words < RANDOM_WORDS + 24)
        begin
            if (phase < 6)
                w = extreme_windows[phase];
            else if ($urandom_range(3) == 0)
                w = WIN_W'($urandom_range(127));
            else
                w = WIN_W'($urandom_range(1, 12));
            set_window(w);
            span = effective_span(w);
            for (int k = $urandom_range(1, 4); k > 0; k--)
            begin
                kind = $urandom_range(99);
                if (kind < 12)
                    add_noise($urandom_range(1, 8));
                else if (kind < 32)
                    add_sequence($urandom_range(1, (span > 1) ? span - 1 : 1), 1'b0, 1'b1);
                else
                    add_sequence($urandom_range(span, 2 * span + 4),
                                 $urandom_range(3) == 0, $urandom_range(9) != 0);
            end
            wait_idle();
            phase++;
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
